// ===== sv/doss_pkg.sv =====
// shared constants and arctangent table for the orientation sector search
package doss_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W = 5;
  localparam logic [31:0] QUARTER_TURN = 32'd4194304;
  localparam logic [14:0] SECTOR_RESET = 15'd10923;
  localparam logic [0:0] ADDR_SECTOR_WIDTH = 1'b0;

  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd2097152;
      5'd1: r = 32'd1238021;
      5'd2: r = 32'd654136;
      5'd3: r = 32'd332050;
      5'd4: r = 32'd166669;
      5'd5: r = 32'd83416;
      5'd6: r = 32'd41718;
      5'd7: r = 32'd20860;
      5'd8: r = 32'd10430;
      5'd9: r = 32'd5215;
      5'd10: r = 32'd2608;
      5'd11: r = 32'd1304;
      5'd12: r = 32'd652;
      5'd13: r = 32'd326;
      5'd14: r = 32'd163;
      5'd15: r = 32'd81;
      5'd16: r = 32'd41;
      5'd17: r = 32'd20;
      5'd18: r = 32'd10;
      5'd19: r = 32'd5;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/doss_ram.sv =====
// generic single-port-write, one-read ram with registered read
module doss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/doss_cordic.sv =====
// iterative cordic phase unit, one rotation per cycle
module doss_cordic
  import doss_pkg::*;
#(
  parameter int IN_W = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [IN_W-1:0] x_in,
  input  logic [IN_W-1:0] y_in,
  output logic            busy,
  output logic            done,
  output logic [15:0]     phase
);
  localparam int W = IN_W + 27;
  logic signed [W-1:0] x, y;
  logic [31:0] z;
  logic [STEP_W-1:0] step;
  logic zero;
  logic signed [W-1:0] sx, sy, xs, ys;
  logic [31:0] zr;

  assign sx = x >>> step;
  assign sy = y >>> step;
  assign xs = W'($signed(x_in)) <<< 24;
  assign ys = W'($signed(y_in)) <<< 24;
  assign zr = z + 32'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        zero <= (x_in == '0) && (y_in == '0);
        if (xs < 0) begin
          if (ys >= 0) begin
            x <= ys; y <= -xs; z <= QUARTER_TURN;
          end else begin
            x <= -ys; y <= xs; z <= 32'd0 - QUARTER_TURN;
          end
        end else begin
          x <= xs; y <= ys; z <= '0;
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + sy; y <= y - sx; z <= z + atan_entry(step);
        end else begin
          x <= x - sy; y <= y + sx; z <= z - atan_entry(step);
        end
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  assign phase = zero ? 16'd0 : zr[23:8];
endmodule

// ===== sv/doss_front.sv =====
// front: accepts responses and queues them two deep
module doss_front (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [32:0] in_data,
  output logic        q_valid,
  input  logic        q_ready,
  output logic [32:0] q_data
);
  logic [32:0] slot [2];
  logic rd, wr;
  logic [1:0] cnt;
  logic push, pop;

  assign in_ready = cnt != 2'd2;
  assign q_valid  = cnt != 2'd0;
  assign q_data   = slot[rd];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0; wr <= 1'b0; cnt <= '0;
    end else begin
      if (push) wr <= ~wr;
      if (pop) rd <= ~rd;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) slot[wr] <= in_data;
  end
endmodule

// ===== sv/doss_back.sv =====
// back: stores responses, runs the sector search and final phase
module doss_back
  import doss_pkg::*;
#(
  parameter int MAX_RESPONSES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [14:0] sector_width,
  input  logic        q_valid,
  output logic        q_ready,
  input  logic [32:0] q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] orientation,
  output logic [7:0]  response_count
);
  localparam int AW = $clog2(MAX_RESPONSES);
  localparam int CW = $clog2(MAX_RESPONSES + 1);
  localparam int SW = 16 + AW;
  localparam int NW = 2 * SW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PHASE = 7'b0000010,
    S_START = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_NORM  = 7'b0010000,
    S_FINAL = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [AW-1:0] s_idx, j_idx;
  logic last_r, stored;
  logic signed [15:0] gx, gy;
  logic signed [SW-1:0] sum_x, sum_y, best_x, best_y;
  logic [NW-1:0] best_norm, sq_x, sq_y;
  logic [15:0] start_phase, diff;
  logic [47:0] rdata;
  logic [AW-1:0] raddr;
  logic scan_valid, scan_last, fetch_start;
  logic c_start, c_busy, c_done;
  logic [SW-1:0] cx, cy;
  logic [15:0] c_phase;
  logic final_run;

  assign q_ready = state == S_IDLE;
  assign raddr = fetch_start ? s_idx : j_idx;

  doss_ram #(.WIDTH(48), .DEPTH(MAX_RESPONSES)) u_ram (
    .clk(clk), .we(state == S_PHASE && c_done && stored),
    .waddr(count[AW-1:0]), .wdata({gx, gy, c_phase}),
    .raddr(raddr), .rdata(rdata)
  );

  assign cx = final_run ? best_x : SW'(gx);
  assign cy = final_run ? best_y : SW'(gy);
  doss_cordic #(.IN_W(SW)) u_cordic (
    .clk(clk), .rst(rst), .start(c_start), .x_in(cx), .y_in(cy),
    .busy(c_busy), .done(c_done), .phase(c_phase)
  );

  assign diff = rdata[15:0] - start_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      c_start <= 1'b0;
      scan_valid <= 1'b0;
      fetch_start <= 1'b0;
      final_run <= 1'b0;
    end else begin
      c_start <= 1'b0;
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            gx <= $signed(q_data[32:17]);
            gy <= $signed(q_data[16:1]);
            last_r <= q_data[0];
            stored <= count < CW'(MAX_RESPONSES);
            final_run <= 1'b0;
            c_start <= 1'b1;
            state <= S_PHASE;
          end
        end
        S_PHASE: begin
          if (c_done) begin
            if (stored) count <= count + 1'b1;
            if (last_r) begin
              best_norm <= '0; best_x <= '0; best_y <= '0;
              s_idx <= '0;
              fetch_start <= 1'b1;
              state <= S_START;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_START: begin
          if (fetch_start) begin
            fetch_start <= 1'b0;
          end else begin
            start_phase <= rdata[15:0];
            sum_x <= '0; sum_y <= '0;
            j_idx <= '0;
            scan_valid <= 1'b1;
            scan_last <= count == CW'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // ram read of j is registered and lands in the next cycle
          if (scan_valid) begin
            if (!scan_last) j_idx <= j_idx + 1'b1;
            scan_valid <= !scan_last;
            scan_last <= CW'(j_idx) + CW'(2) == count;
          end
          if (!scan_valid || j_idx != '0) begin
            if ({1'b0, diff} <= {2'b0, sector_width}) begin
              sum_x <= sum_x + SW'($signed(rdata[47:32]));
              sum_y <= sum_y + SW'($signed(rdata[31:16]));
            end
          end
          if (!scan_valid) state <= S_NORM;
        end
        S_NORM: begin
          if (sq_x + sq_y > best_norm) begin
            best_norm <= sq_x + sq_y;
            best_x <= sum_x; best_y <= sum_y;
          end
          if (CW'(s_idx) + CW'(1) == count) begin
            final_run <= 1'b1;
            state <= S_FINAL;
          end else begin
            s_idx <= s_idx + 1'b1;
            fetch_start <= 1'b1;
            state <= S_START;
          end
        end
        S_FINAL: begin
          if (best_norm == '0) begin
            state <= S_OUT;
          end else if (!c_busy && !c_done && !c_start) begin
            c_start <= 1'b1;
          end else if (c_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            orientation <= best_norm == '0 ? 16'd0 : c_phase;
            response_count <= 8'(count);
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // first scan cycle has no data yet; accumulate from next cycle on
  always_comb begin
    sq_x = NW'(sum_x) * NW'(sum_x);
    sq_y = NW'(sum_y) * NW'(sum_y);
  end
endmodule

// ===== sv/dominant_orientation_sector_search.sv =====
// top level of the dominant orientation sector search
// the back takes a new response only after the 20-step shared cordic finishes the last one
// each window start rescans all stored responses through the single ram read port
// rst is synchronous active high; clears count and handshakes, restores sector_width
// the response ram has no reset and needs no clearing pass
module dominant_orientation_sector_search
  import doss_pkg::*;
#(
  parameter int MAX_RESPONSES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] grad_x,
  input  logic [15:0] grad_y,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] orientation,
  output logic [7:0]  response_count
);
  logic [14:0] sector_width;
  logic q_valid, q_ready;
  logic [32:0] q_data;
  logic sel_sw;

  assign pready = 1'b1;
  assign sel_sw = paddr[2] == ADDR_SECTOR_WIDTH && paddr[1:0] == 2'b00;
  assign prdata = sel_sw ? {17'd0, sector_width} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_width <= SECTOR_RESET;
    end else if (psel && penable && pwrite && sel_sw) begin
      sector_width <= pwdata[14:0];
    end
  end

  doss_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data({grad_x, grad_y, last}),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  doss_back #(.MAX_RESPONSES(MAX_RESPONSES)) u_back (
    .clk(clk), .rst(rst), .sector_width(sector_width),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .orientation(orientation), .response_count(response_count)
  );
endmodule

// ===== sv/doss_checker.sv =====
// port-level checker for the orientation sector search
module doss_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] orientation,
  input logic [7:0]  response_count
);
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input transfer dropped");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(orientation))
    else $error("result dropped");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> response_count != 8'd0) else $error("empty set");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind dominant_orientation_sector_search doss_checker u_checker (
  .clk(clk), .rst(rst), .pready(pready), .in_valid(in_valid),
  .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
  .orientation(orientation), .response_count(response_count)
);
